/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl files, included by mm4_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be true
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_PROP(lbl, !(cond), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* hw/rtl/mm4_pkg.sv */
package mm4_pkg;

    // default matrix dimension
    localparam int DEFAULT_DIM = 4;
    // element width, q16.16
    localparam int VAL_W = 32;
    // fraction bits dropped after the sum
    localparam int FRAC_W = 16;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // write the item into both stores
        logic issue;      // read one a/b pair for a multiply-accumulate
        logic mac_first;  // first term of a dot product
        logic mac_last;   // last term of a dot product
        logic elem_last;  // last term of the last element
    } ctrl_cmd_t;

endpackage

/* hw/rtl/mm4_ctrl.sv */
`include "assert_macros.svh"

module mm4_ctrl
    import mm4_pkg::*;
#(
    parameter int MATRIX_DIM = DEFAULT_DIM
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    output logic                                       busy,
    output ctrl_cmd_t                                  cmd,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   wr_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   a_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   b_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   elem_idx
);

    localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
    localparam int IW    = $clog2(CELLS);
    localparam int DW    = $clog2(MATRIX_DIM);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic          state_reg, state_next;
    logic [IW-1:0] load_cnt_reg, load_cnt_next;
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic [DW-1:0] k_reg, k_next;
    logic          k_end, row_end, col_end;

    assign k_end   = (k_reg == DW'(MATRIX_DIM - 1));
    assign row_end = (row_reg == DW'(MATRIX_DIM - 1));
    assign col_end = (col_reg == DW'(MATRIX_DIM - 1));

    always_comb
    begin
        cmd.load      = start && (state_reg == ST_LOAD);
        cmd.issue     = (state_reg == ST_RUN);
        cmd.mac_first = (k_reg == '0);
        cmd.mac_last  = k_end;
        cmd.elem_last = (state_reg == ST_RUN) && k_end && row_end && col_end;
    end

    assign busy     = (state_reg == ST_RUN);
    assign wr_addr  = load_cnt_reg;
    assign a_addr   = IW'(k_reg * MATRIX_DIM + row_reg);
    assign b_addr   = IW'(col_reg * MATRIX_DIM + k_reg);
    assign elem_idx = IW'(col_reg * MATRIX_DIM + row_reg);

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        k_next        = k_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    if (load_cnt_reg == IW'(CELLS - 1))
                    begin
                        load_cnt_next = '0;
                        state_next    = ST_RUN;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                // k innermost, then row, then column
                if (k_end)
                begin
                    k_next = '0;
                    if (row_end)
                    begin
                        row_next = '0;
                        if (col_end)
                        begin
                            col_next   = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            k_reg        <= k_next;
        end
    end

    `ASSERT_PROP(a_run_after_fill, (cmd.load && (load_cnt_reg == IW'(CELLS - 1))) |=> busy, "no run after full load")
    `ASSERT_PROP(a_run_ends, cmd.elem_last |=> !busy, "run did not end after last term")
    `ASSERT_PROP(a_run_starts_clean, $rose(busy) |-> (cmd.mac_first && (col_reg == '0) && (row_reg == '0)), "run started mid product")
    `ASSERT_PROP(a_load_count_idle, busy |-> (load_cnt_reg == '0), "load count moved during run")

endmodule

/* hw/rtl/mm4_datapath.sv */
module mm4_datapath
    import mm4_pkg::*;
#(
    parameter int MATRIX_DIM = DEFAULT_DIM
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  ctrl_cmd_t                                  cmd,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   wr_addr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   a_addr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   b_addr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   elem_idx,
    input  logic signed [VAL_W-1:0]                    a_elem,
    input  logic signed [VAL_W-1:0]                    b_elem,
    output logic                                       out_valid,
    output logic signed [VAL_W-1:0]                    out_value,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   out_index,
    output logic                                       out_last
);

    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int IW     = $clog2(CELLS);
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(MATRIX_DIM);

    logic signed [VAL_W-1:0]  a_mem [CELLS];
    logic signed [VAL_W-1:0]  b_mem [CELLS];

    logic signed [VAL_W-1:0]  a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [IW-1:0]            idx1_reg, idx2_reg, idx3_reg;
    ctrl_cmd_t                s1_reg, s2_reg, s3_reg;
    logic                     out_valid_reg;
    logic signed [VAL_W-1:0]  out_value_reg, sat_value;
    logic [IW-1:0]            out_index_reg;
    logic                     out_last_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-VAL_W:0]     upper;

    // stores, one write port and one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_mem[wr_addr] <= a_elem;
            b_mem[wr_addr] <= b_elem;
        end
        if (cmd.issue)
        begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr];
        end
    end

    // exact sum of the products, floor shift, saturate
    always_comb
    begin
        if (s2_reg.mac_first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    assign shifted = acc_reg >>> FRAC_W;
    assign upper   = shifted[ACC_W-1:VAL_W-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
            sat_value = shifted[VAL_W-1:0];
        else if (upper[ACC_W-VAL_W])
            sat_value = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_value = {1'b0, {(VAL_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            idx1_reg <= elem_idx;
        if (s1_reg.issue)
        begin
            prod_reg <= a_rd_reg * b_rd_reg;
            idx2_reg <= idx1_reg;
        end
        if (s2_reg.issue)
        begin
            acc_reg  <= acc_next;
            idx3_reg <= idx2_reg;
        end
        if (s3_reg.issue && s3_reg.mac_last)
        begin
            out_value_reg <= sat_value;
            out_index_reg <= idx3_reg;
            out_last_reg  <= s3_reg.elem_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= cmd;
            s2_reg        <= s1_reg;
            s3_reg        <= s2_reg;
            out_valid_reg <= s3_reg.issue && s3_reg.mac_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

/* hw/rtl/matrix_multiply_4x4.sv */
// matrix product c = a * b, column-major, signed q16.16, one a/b pair per item
// loading: one item per cycle while busy is low; the sixteenth item starts a run
// run: busy is high while all dim^3 = 64 multiply-accumulates issue, one per cycle
// results: one per element, through the read, product, accumulate and output registers
// the next matrix pair loads only after the run ends, set by the single multiplier
// reset (async, rst_n low) clears the load count and the controller; stores are not cleared
module matrix_multiply_4x4
    import mm4_pkg::*;
#(
    parameter int MATRIX_DIM = DEFAULT_DIM
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    // item handshake: taken when start is high and busy is low
    input  logic                                       start,
    output logic                                       busy,
    input  logic signed [VAL_W-1:0]                    a_elem,
    input  logic signed [VAL_W-1:0]                    b_elem,
    // result strobe: one cycle per result, no back-pressure
    output logic                                       out_valid,
    output logic signed [VAL_W-1:0]                    out_value,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]   out_index,
    output logic                                       out_last
);

    localparam int IW = $clog2(MATRIX_DIM * MATRIX_DIM);

    // commands from the sequencer to the arithmetic
    ctrl_cmd_t     cmd;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] a_addr;
    logic [IW-1:0] b_addr;
    logic [IW-1:0] elem_idx;

    // sequencer: load count, then the column/row/k sweep of the product
    mm4_ctrl #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .a_addr   (a_addr),
        .b_addr   (b_addr),
        .elem_idx (elem_idx)
    );

    // stores for a and b, multiplier, accumulator and the saturating output stage
    mm4_datapath #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .elem_idx  (elem_idx),
        .a_elem    (a_elem),
        .b_elem    (b_elem),
        .out_valid (out_valid),
        .out_value (out_value),
        .out_index (out_index),
        .out_last  (out_last)
    );

endmodule
